FILE: src/laa_pkg.sv
// Shared constants, types and codes of the LIFO arena allocator.
`default_nettype none

package laa_pkg;

  // Sizing of the arena, the entry stack and the screen pool.
  localparam int ARENA_BYTES  = 65536;
  localparam int MAX_ENTRIES  = 64;
  localparam int SCREEN_SLOTS = 2;

  // Widths that follow from the sizing.
  localparam int TOP_W      = $clog2(ARENA_BYTES + 1);
  localparam int DEPTH_W    = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SLOT_IDX_W = (SCREEN_SLOTS > 1) ? $clog2(SCREEN_SLOTS) : 1;

  // Fixed field widths of the channels.
  localparam int DIM_W    = 12;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 2;
  localparam int STATUS_W = 3;
  localparam int OFF_W    = 16;
  localparam int PITCH_W  = 13;
  localparam int TOPO_W   = 17;
  localparam int DEPO_W   = 7;
  localparam int PROD_W   = PITCH_W + DIM_W;
  localparam int SUM_W    = ((PROD_W > TOP_W) ? PROD_W : TOP_W) + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 12'd200;

  // Request modes.
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_POOL_FULL  = 3'd2,
    ST_ARENA_FULL = 3'd3,
    ST_STACK_FULL = 3'd4
  } laa_status_t;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] req_width;
    logic [DIM_W-1:0] req_height;
    logic [TAG_W-1:0] owner_tag;
    logic [SLOT_W-1:0] release_slot;
    logic             release_arena;
  } laa_req_t;

  typedef struct packed {
    laa_status_t        status;
    logic               from_pool;
    logic [SLOT_W-1:0]  granted_slot;
    logic [OFF_W-1:0]   byte_offset;
    logic [PITCH_W-1:0] row_pitch;
    logic [TOPO_W-1:0]  top_after;
    logic [DEPO_W-1:0]  depth_after;
  } laa_res_t;

  // One word of the entry stack memory.
  typedef struct packed {
    logic [TAG_W-1:0] owner;
    logic [TOP_W-1:0] base;
    logic             dead;
  } laa_entry_t;

  localparam int ENTRY_W = $bits(laa_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic bad;
    logic pool_alloc;
    logic pool_free;
    logic mul;
    logic bump;
    logic srch_init;
    logic srch_rd;
    logic srch_dec;
    logic mark;
    logic unw_rd;
    logic pop;
    logic emit;
  } laa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alloc;
    logic bad_size;
    logic screen;
    logic rel_slot;
    logic rel_arena;
    logic depth_zero;
    logic idx_zero;
    logic match;
    logic dead;
    logic out_free;
  } laa_sts_t;

endpackage

`default_nettype wire

FILE: src/laa_if.sv
// Handshake interfaces of the request, result and configuration channels.
`default_nettype none

interface laa_req_if;
  import laa_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [DIM_W-1:0]  req_width;
  logic [DIM_W-1:0]  req_height;
  logic [TAG_W-1:0]  owner_tag;
  logic [SLOT_W-1:0] release_slot;
  logic              release_arena;

  modport source (
    output valid, mode, req_width, req_height, owner_tag, release_slot, release_arena,
    input  ready
  );
  modport sink (
    input  valid, mode, req_width, req_height, owner_tag, release_slot, release_arena,
    output ready
  );
endinterface

interface laa_res_if;
  import laa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                from_pool;
  logic [SLOT_W-1:0]   granted_slot;
  logic [OFF_W-1:0]    byte_offset;
  logic [PITCH_W-1:0]  row_pitch;
  logic [TOPO_W-1:0]   top_after;
  logic [DEPO_W-1:0]   depth_after;

  modport source (
    output valid, status, from_pool, granted_slot, byte_offset, row_pitch, top_after,
           depth_after,
    input  ready
  );
  modport sink (
    input  valid, status, from_pool, granted_slot, byte_offset, row_pitch, top_after,
           depth_after,
    output ready
  );
endinterface

interface laa_cfg_if;
  import laa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/laa_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module laa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/laa_ctrl.sv
// Controller state machine that sequences allocation, search and unwind.
`default_nettype none

module laa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire laa_pkg::laa_sts_t sts,
  output laa_pkg::laa_cmd_t      cmd
);
  import laa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_MUL    = 9'b000000100,
    S_BUMP   = 9'b000001000,
    S_SRD    = 9'b000010000,
    S_SCHK   = 9'b000100000,
    S_URD    = 9'b001000000,
    S_UCHK   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } laa_state_t;

  laa_state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.alloc) begin
          if (sts.bad_size) begin
            cmd.bad   = 1'b1;
            state_nxt = S_EMIT;
          end else if (sts.screen) begin
            cmd.pool_alloc = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (sts.rel_slot) begin
          cmd.pool_free = 1'b1;
          state_nxt     = S_EMIT;
        end else if (sts.rel_arena) begin
          if (sts.depth_zero) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.srch_init = 1'b1;
            state_nxt     = S_SRD;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_BUMP;
      end
      S_BUMP: begin
        cmd.bump  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_SRD: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SCHK;
      end
      S_SCHK: begin
        if (sts.match) begin
          cmd.mark  = 1'b1;
          state_nxt = S_URD;
        end else if (sts.idx_zero) begin
          state_nxt = S_URD;
        end else begin
          cmd.srch_dec = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_URD: begin
        if (sts.depth_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.unw_rd = 1'b1;
          state_nxt  = S_UCHK;
        end
      end
      S_UCHK: begin
        if (sts.dead) begin
          cmd.pop   = 1'b1;
          state_nxt = S_URD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/laa_dp.sv
// Datapath: request latch, arena pointer, entry stack memory, pool and result register.
`default_nettype none

module laa_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire laa_pkg::laa_req_t               req,
  input  wire laa_pkg::laa_cmd_t               cmd,
  output laa_pkg::laa_sts_t                    sts,
  input  wire logic                            cfg_we,
  input  wire logic [laa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [laa_pkg::DIM_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output laa_pkg::laa_res_t                    out_res
);
  import laa_pkg::*;

  logic [DIM_W-1:0]   scr_w_r, scr_h_r;
  laa_req_t           req_r;
  logic [TOP_W-1:0]   top_r;
  logic [DEPTH_W-1:0] depth_r;
  logic               slot_busy_r [SCREEN_SLOTS];
  logic [IDX_W-1:0]   idx_r;
  logic [PROD_W-1:0]  prod_r;

  laa_status_t        st_status_r;
  logic [SLOT_W-1:0]  st_slot_r;
  logic [OFF_W-1:0]   st_off_r;
  logic [PITCH_W-1:0] st_pitch_r;

  logic               out_valid_r;
  laa_res_t           out_r;

  logic [PITCH_W-1:0]  pitch;
  logic [DEPTH_W-1:0]  depth_m1;
  logic [SUM_W-1:0]    sum;
  logic [TOP_W-1:0]    top_nxt;
  logic                stack_full, exhausted, push_ok;
  logic                free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [SLOT_IDX_W:0]   free_num;
  logic                out_free;

  laa_entry_t          ent;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  laa_entry_t          ram_wdata;

  // Pitch is the width rounded up to a multiple of four bytes.
  assign pitch    = ({1'b0, req_r.req_width} + PITCH_W'(3)) & ~PITCH_W'(3);
  assign depth_m1 = depth_r - DEPTH_W'(1);

  assign sum        = SUM_W'(top_r) + SUM_W'(prod_r);
  assign stack_full = (depth_r >= DEPTH_W'(MAX_ENTRIES));
  assign exhausted  = (sum > SUM_W'(ARENA_BYTES));
  assign push_ok    = !stack_full && !exhausted;
  assign top_nxt    = TOP_W'((sum + SUM_W'(3)) & ~SUM_W'(3));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    free_num   = '0;
    for (int i = 0; i < SCREEN_SLOTS; i++) begin
      if (!free_found && !slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
        free_num   = (SLOT_IDX_W + 1)'(i + 1);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Entry stack memory: pushes and dead marks write, search and unwind read.
  assign ram_we    = (cmd.bump && push_ok) || cmd.mark;
  assign ram_waddr = cmd.mark ? idx_r : depth_r[IDX_W-1:0];
  assign ram_wdata = cmd.mark ? laa_entry_t'{owner: ent.owner, base: ent.base, dead: 1'b1}
                              : laa_entry_t'{owner: req_r.owner_tag, base: top_r, dead: 1'b0};
  assign ram_raddr = cmd.unw_rd ? depth_m1[IDX_W-1:0] : idx_r;

  laa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ent)
  );

  always_comb begin
    sts            = '0;
    sts.alloc      = (req_r.mode == MODE_ALLOC);
    sts.bad_size   = (req_r.req_width == '0) || (req_r.req_height == '0);
    sts.screen     = (req_r.req_width == scr_w_r) && (req_r.req_height == scr_h_r);
    sts.rel_slot   = (req_r.release_slot != '0);
    sts.rel_arena  = req_r.release_arena;
    sts.depth_zero = (depth_r == '0);
    sts.idx_zero   = (idx_r == '0);
    sts.match      = (ent.owner == req_r.owner_tag);
    sts.dead       = ent.dead;
    sts.out_free   = out_free;
  end

  // Control state: configuration, arena pointer, stack depth, pool and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r     <= SCREEN_WIDTH_RST;
      scr_h_r     <= SCREEN_HEIGHT_RST;
      top_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SCREEN_SLOTS; i++) begin
        slot_busy_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        endcase
      end
      if (cmd.pool_alloc && free_found) begin
        slot_busy_r[free_idx] <= 1'b1;
      end
      if (cmd.pool_free) begin
        for (int i = 0; i < SCREEN_SLOTS; i++) begin
          if (int'(req_r.release_slot) == i + 1) begin
            slot_busy_r[i] <= 1'b0;
          end
        end
      end
      if (cmd.bump && push_ok) begin
        top_r   <= top_nxt;
        depth_r <= depth_r + DEPTH_W'(1);
      end
      if (cmd.pop) begin
        top_r   <= ent.base;
        depth_r <= depth_m1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r       <= req;
      st_status_r <= ST_OK;
      st_slot_r   <= '0;
      st_off_r    <= '0;
      st_pitch_r  <= '0;
    end
    if (cmd.bad) begin
      st_status_r <= ST_BAD_SIZE;
    end
    if (cmd.pool_alloc) begin
      if (free_found) begin
        st_slot_r  <= SLOT_W'(free_num);
        st_pitch_r <= PITCH_W'(scr_w_r);
      end else begin
        st_status_r <= ST_POOL_FULL;
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(pitch) * PROD_W'(req_r.req_height);
    end
    if (cmd.bump) begin
      if (stack_full) begin
        st_status_r <= ST_STACK_FULL;
      end else if (exhausted) begin
        st_status_r <= ST_ARENA_FULL;
      end else begin
        st_off_r   <= OFF_W'(top_r);
        st_pitch_r <= pitch;
      end
    end
    if (cmd.srch_init) begin
      idx_r <= depth_m1[IDX_W-1:0];
    end else if (cmd.srch_dec) begin
      idx_r <= idx_r - IDX_W'(1);
    end
    if (cmd.emit) begin
      out_r.status       <= st_status_r;
      out_r.from_pool    <= (st_slot_r != '0);
      out_r.granted_slot <= st_slot_r;
      out_r.byte_offset  <= st_off_r;
      out_r.row_pitch    <= st_pitch_r;
      out_r.top_after    <= TOPO_W'(top_r);
      out_r.depth_after  <= DEPO_W'(depth_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

FILE: src/lifo_arena_allocator_core.sv
// Top level of the LIFO arena allocator: controller, datapath and channel wiring.
//
//   Channel | Interface      | Direction | Carries
//   --------+----------------+-----------+-----------------------------------------------
//   in_if   | laa_req_if     | sink      | one allocate or release request per item
//   out_if  | laa_res_if     | source    | one result item per request
//   cfg_if  | laa_cfg_if     | sink      | screen_width (index 0), screen_height (index 1)
//
// The block works on one request at a time. A pool request, a bad size or a pool
// release goes from decode straight to the result register; an arena allocation
// first registers the pitch times height product, then bumps the pointer. An arena
// release from an empty stack also goes straight to the result. Otherwise it reads
// and checks each entry searched, each dead entry unwound and any live entry that
// ends the unwind, as each step is one access to the single-read memory.
// Reset (rst_n low, synchronous) empties the arena, the stack and the pool and
// loads the screen size 320 by 200; the entry memory is not cleared. A waiting
// result does not block acceptance of the next item; only delivery of the
// following result waits until the output register has been taken.
`default_nettype none

module lifo_arena_allocator_core (
  input wire logic clk,
  input wire logic rst_n,
  laa_req_if.sink   in_if,
  laa_res_if.source out_if,
  laa_cfg_if.sink   cfg_if
);
  import laa_pkg::*;

  laa_req_t req;
  laa_res_t res;
  laa_cmd_t cmd;
  laa_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Pack the request fields into one word for the datapath latch.
  assign req.mode          = in_if.mode;
  assign req.req_width     = in_if.req_width;
  assign req.req_height    = in_if.req_height;
  assign req.owner_tag     = in_if.owner_tag;
  assign req.release_slot  = in_if.release_slot;
  assign req.release_arena = in_if.release_arena;
  assign in_if.ready       = in_ready;

  // Configuration writes are always taken; the user must issue them only while idle (not enforced).
  assign cfg_if.ready = 1'b1;

  // The controller owns the sequence of steps for each item.
  laa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath holds the allocator state and the result register.
  laa_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_if.valid),
    .cfg_idx  (cfg_if.index),
    .cfg_data (cfg_if.data),
    .out_valid(out_valid),
    .out_ready(out_if.ready),
    .out_res  (res)
  );

  // Unpack the result register onto the output channel.
  assign out_if.valid        = out_valid;
  assign out_if.status       = res.status;
  assign out_if.from_pool    = res.from_pool;
  assign out_if.granted_slot = res.granted_slot;
  assign out_if.byte_offset  = res.byte_offset;
  assign out_if.row_pitch    = res.row_pitch;
  assign out_if.top_after    = res.top_after;
  assign out_if.depth_after  = res.depth_after;

endmodule

`default_nettype wire

FILE: src/laa_checker.sv
// Port-level assertions for the LIFO arena allocator and their bind to the top level.
`default_nettype none

module laa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [laa_pkg::STATUS_W-1:0]  status,
  input wire logic                          from_pool,
  input wire logic [laa_pkg::SLOT_W-1:0]    granted_slot,
  input wire logic [laa_pkg::OFF_W-1:0]     byte_offset,
  input wire logic [laa_pkg::PITCH_W-1:0]   row_pitch,
  input wire logic [laa_pkg::TOPO_W-1:0]    top_after,
  input wire logic [laa_pkg::DEPO_W-1:0]    depth_after
);
  import laa_pkg::*;

  // A result that is not taken stays valid with its status, offset, pointer and depth unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_offset)
      && $stable(top_after) && $stable(depth_after))
    else $error("result changed while stalled");

  // The block takes one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // A pool grant and a nonzero slot number go together.
  a_pool_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> from_pool == (granted_slot != '0))
    else $error("pool flag and slot disagree");

  // A failed request carries no buffer description.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> !from_pool && byte_offset == '0 && row_pitch == '0)
    else $error("failed request carries a buffer");

  // The reported stack depth and bump pointer stay within their sizes.
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> depth_after <= DEPO_W'(MAX_ENTRIES) && top_after <= TOPO_W'(ARENA_BYTES))
    else $error("depth or pointer beyond its limit");

endmodule

bind lifo_arena_allocator_core laa_checker u_laa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .status      (out_if.status),
  .from_pool   (out_if.from_pool),
  .granted_slot(out_if.granted_slot),
  .byte_offset (out_if.byte_offset),
  .row_pitch   (out_if.row_pitch),
  .top_after   (out_if.top_after),
  .depth_after (out_if.depth_after)
);

`default_nettype wire

FILE: bench/tb_lifo_arena_allocator_core.sv
// Self-checking testbench for the LIFO arena allocator core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_lifo_arena_allocator_core;
  import laa_pkg::*;

  // Longest stretch without any handshake before the run is declared hung. The slowest
  // legal item is an arena release that walks and unwinds the whole stack, behind a
  // choked receiver and a sender gap, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 5000;

  // Cycles allowed after the last result, enough for a full-depth release to finish.
  localparam int TAIL_CYCLES = 300;

  // Receiver behavior, chosen afresh for each stretch of cycles.
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_style_t;

  // One row of the directed table. When typed is set, want holds a result read
  // straight off the specification; otherwise the predictor supplies it.
  typedef struct {
    laa_req_t req;
    bit       typed;
    laa_res_t want;
  } script_row_t;

  logic clk;
  logic rst_n;

  laa_req_if in_ch ();
  laa_res_if out_ch ();
  laa_cfg_if cfg_ch ();

  lifo_arena_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor state: screen size registers, bump pointer, entry stack and pool.
  logic [DIM_W-1:0]   screen_w;
  logic [DIM_W-1:0]   screen_h;
  logic [TOP_W-1:0]   bump_top;
  logic [DEPTH_W-1:0] live_depth;
  logic [TAG_W-1:0]   tag_of  [MAX_ENTRIES];
  logic [TOP_W-1:0]   base_of [MAX_ENTRIES];
  bit                 dead_of [MAX_ENTRIES];
  bit                 slot_taken [SCREEN_SLOTS];

  laa_res_t    expected_results[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    screen_w   = SCREEN_WIDTH_RST;
    screen_h   = SCREEN_HEIGHT_RST;
    bump_top   = '0;
    live_depth = '0;
    foreach (slot_taken[s]) slot_taken[s] = 1'b0;
  endfunction

  // Applies one accepted request to the predicted state and returns its result.
  function automatic laa_res_t serve_request(laa_req_t r);
    laa_res_t res;
    int       pitch;
    int       bytes;
    int       i;
    bit       hit;

    res = '0;
    res.status = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      if (r.req_width == 0 || r.req_height == 0) begin
        res.status = ST_BAD_SIZE;
      end else if (r.req_width == screen_w && r.req_height == screen_h) begin
        // A screen-sized request takes the lowest free pool slot.
        hit = 1'b0;
        for (i = 0; i < SCREEN_SLOTS; i++) begin
          if (!hit && !slot_taken[i]) begin
            hit = 1'b1;
            slot_taken[i] = 1'b1;
            res.from_pool = 1'b1;
            res.granted_slot = SLOT_W'(i + 1);
            res.row_pitch = PITCH_W'(screen_w);
          end
        end
        if (!hit) res.status = ST_POOL_FULL;
      end else begin
        pitch = (int'(r.req_width) + 3) & ~3;
        bytes = pitch * int'(r.req_height);
        // The stack limit is checked ahead of the arena space.
        if (live_depth >= MAX_ENTRIES) begin
          res.status = ST_STACK_FULL;
        end else if (int'(bump_top) + bytes > ARENA_BYTES) begin
          res.status = ST_ARENA_FULL;
        end else begin
          tag_of[live_depth]  = r.owner_tag;
          base_of[live_depth] = bump_top;
          dead_of[live_depth] = 1'b0;
          live_depth++;
          res.byte_offset = OFF_W'(bump_top);
          res.row_pitch = PITCH_W'(pitch);
          bump_top = TOP_W'((int'(bump_top) + bytes + 3) & ~3);
        end
      end
    end else if (r.release_slot != 0) begin
      // A pool slot wins over the arena flag; a slot past the pool is ignored.
      if (int'(r.release_slot) - 1 < SCREEN_SLOTS) slot_taken[r.release_slot - 1] = 1'b0;
    end else if (r.release_arena) begin
      // Mark the topmost entry carrying the tag, then pop dead entries off the top.
      hit = 1'b0;
      for (i = int'(live_depth) - 1; i >= 0; i--) begin
        if (!hit && tag_of[i] == r.owner_tag) begin
          hit = 1'b1;
          dead_of[i] = 1'b1;
        end
      end
      while (live_depth != 0 && dead_of[live_depth - 1]) begin
        live_depth--;
        bump_top = base_of[live_depth];
      end
    end
    res.top_after = TOPO_W'(bump_top);
    res.depth_after = DEPO_W'(live_depth);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic laa_req_t mk_req(logic mode, int w, int h, int tag, int slot, int arena);
    laa_req_t r;
    r.mode = mode;
    r.req_width = DIM_W'(w);
    r.req_height = DIM_W'(h);
    r.owner_tag = TAG_W'(tag);
    r.release_slot = SLOT_W'(slot);
    r.release_arena = 1'(arena);
    return r;
  endfunction

  function automatic laa_res_t mk_res(laa_status_t status, int pool, int slot, int offset,
                                      int pitch, int top, int depth);
    laa_res_t res;
    res.status = status;
    res.from_pool = 1'(pool);
    res.granted_slot = SLOT_W'(slot);
    res.byte_offset = OFF_W'(offset);
    res.row_pitch = PITCH_W'(pitch);
    res.top_after = TOPO_W'(top);
    res.depth_after = DEPO_W'(depth);
    return res;
  endfunction

  function automatic void add_step(laa_req_t r, bit typed = 1'b0, laa_res_t want = '0);
    script_row_t row;
    row.req = r;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  // Index of a random entry that is still alive, or -1 when none was found.
  function automatic int live_index();
    int tries;
    int j;
    int pick;
    pick = -1;
    if (live_depth != 0) begin
      for (tries = 0; tries < 4 && pick < 0; tries++) begin
        j = $urandom_range(0, int'(live_depth) - 1);
        if (!dead_of[j]) pick = j;
      end
    end
    return pick;
  endfunction

  // Random request. Most items are well formed: allocations of modest size and
  // releases of buffers that are really on the stack. The rest is bad sizes, pool
  // traffic, stray releases and items with every field random.
  function automatic laa_req_t pick_request();
    laa_req_t r;
    int       roll;
    int       k;

    r = mk_req(MODE_ALLOC, $urandom, $urandom, $urandom, $urandom, $urandom);
    roll = $urandom_range(0, 99);
    // Near the stack limit, lean on releases so the stack keeps moving.
    if (live_depth >= 56 && roll < 45) roll = $urandom_range(58, 79);
    k = live_index();

    if (roll < 40) begin
      r.req_width = DIM_W'($urandom_range(1, 64));
      r.req_height = DIM_W'($urandom_range(1, 32));
      if (k >= 0 && $urandom_range(0, 4) == 0) r.owner_tag = tag_of[k];
    end else if (roll < 45) begin
      r.req_width = DIM_W'($urandom_range(1, 4095));
      r.req_height = DIM_W'($urandom_range(1, 64));
    end else if (roll < 55) begin
      r.req_width = screen_w;
      r.req_height = screen_h;
    end else if (roll < 58) begin
      if ($urandom_range(0, 1) == 0) r.req_width = '0;
      else r.req_height = '0;
    end else if (roll < 80) begin
      r.mode = MODE_RELEASE;
      r.release_slot = '0;
      r.release_arena = 1'b1;
      if (k >= 0) r.owner_tag = tag_of[k];
    end else if (roll < 84) begin
      r.mode = MODE_RELEASE;
      r.release_slot = '0;
      r.release_arena = 1'b1;
    end else if (roll < 91) begin
      r.mode = MODE_RELEASE;
      r.release_slot = SLOT_W'($urandom_range(1, 3));
    end else if (roll < 95) begin
      r.mode = MODE_RELEASE;
      r.release_slot = '0;
      r.release_arena = 1'b0;
    end else begin
      r.mode = 1'($urandom);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request channel driver
  // ---------------------------------------------------------------------------

  // The sender works in bursts. Between bursts valid often drops for a random gap, and
  // some bursts are long, so there are stretches with back-to-back items.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Presents one item and waits for it to be taken. The prediction is made at the
  // accepting edge so that the next random item sees the up-to-date state.
  task automatic offer_request(input laa_req_t r, input bit typed, input laa_res_t want);
    laa_res_t predicted;
    pace_sender();
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= r.mode;
    in_ch.req_width <= r.req_width;
    in_ch.req_height <= r.req_height;
    in_ch.owner_tag <= r.owner_tag;
    in_ch.release_slot <= r.release_slot;
    in_ch.release_arena <= r.release_arena;
    do @(posedge clk); while (!in_ch.ready);
    predicted = serve_request(r);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic run_random(input int count);
    repeat (count) offer_request(pick_request(), 1'b0, '0);
  endtask

  // Lowers valid and waits until every result is back. Each item yields exactly
  // one result, so an empty queue means the block is idle.
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_screen_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= DIM_W'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_SCREEN_WIDTH) screen_w = DIM_W'(val);
    else screen_h = DIM_W'(val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Empties the stack from the top, fills it to the limit, pushes past the limit
  // (once with a size that would also exhaust the arena, to check which error wins),
  // then frees everything in random order so dead entries pile up below live ones.
  task automatic exercise_stack_limit();
    int k;
    while (live_depth != 0) begin
      offer_request(mk_req(MODE_RELEASE, $urandom, $urandom, int'(tag_of[live_depth - 1]),
                           0, 1), 1'b0, '0);
    end
    while (live_depth < MAX_ENTRIES) begin
      offer_request(mk_req(MODE_ALLOC, $urandom_range(1, 8), $urandom_range(1, 8), $urandom,
                           $urandom, $urandom), 1'b0, '0);
    end
    offer_request(mk_req(MODE_ALLOC, 4000, 4000, $urandom, 0, 0), 1'b0, '0);
    offer_request(mk_req(MODE_ALLOC, 1, 1, $urandom, 0, 0), 1'b0, '0);
    while (live_depth != 0) begin
      k = live_index();
      if (k < 0) k = int'(live_depth) - 1;
      offer_request(mk_req(MODE_RELEASE, $urandom, $urandom, int'(tag_of[k]), 0, 1),
                    1'b0, '0);
    end
  endtask

  // Directed table, run from reset with the default 320 by 200 screen size.
  function automatic void build_script();
    // Releasing from an empty stack changes nothing.
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h0000, 0, 1), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 0, 0, 0));
    // Zero width or zero height is a bad size.
    add_step(mk_req(MODE_ALLOC, 0, 5, 16'h0102, 0, 0), 1'b1,
             mk_res(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0));
    add_step(mk_req(MODE_ALLOC, 4095, 0, 16'h0203, 3, 1), 1'b1,
             mk_res(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0));
    // Screen-sized requests fill the pool, and the next one finds it full.
    add_step(mk_req(MODE_ALLOC, 320, 200, 16'h0304, 0, 0), 1'b1,
             mk_res(ST_OK, 1, 1, 0, 320, 0, 0));
    add_step(mk_req(MODE_ALLOC, 320, 200, 16'h0405, 0, 0), 1'b1,
             mk_res(ST_OK, 1, 2, 0, 320, 0, 0));
    add_step(mk_req(MODE_ALLOC, 320, 200, 16'h0506, 0, 0), 1'b1,
             mk_res(ST_POOL_FULL, 0, 0, 0, 0, 0, 0));
    // A slot past the pool is ignored, and it still keeps the arena flag from acting.
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h0000, 3, 1), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 0, 0, 0));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h0000, 1, 0), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 0, 0, 0));
    // Freeing a slot that is already free, then a pool release that also names the arena.
    add_step(mk_req(MODE_RELEASE, 4095, 4095, 16'hFFFF, 1, 0));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h0000, 2, 1));
    // Smallest arena buffer, then the widest row, then a size that cannot fit.
    add_step(mk_req(MODE_ALLOC, 1, 1, 16'h0001, 0, 0), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 4, 4, 1));
    add_step(mk_req(MODE_ALLOC, 4095, 1, 16'hFFFF, 0, 0));
    add_step(mk_req(MODE_ALLOC, 4095, 4095, 16'h0000, 0, 0), 1'b1,
             mk_res(ST_ARENA_FULL, 0, 0, 0, 0, 4100, 2));
    add_step(mk_req(MODE_ALLOC, 3, 7, 16'h1234, 0, 0));
    add_step(mk_req(MODE_ALLOC, 5, 3, 16'h5678, 0, 0));
    // Out-of-order release of the bottom entry, an unknown tag, and a release
    // that names neither source.
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h0001, 0, 1));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'hABCD, 0, 1));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h5678, 0, 0));
    // Releasing from the top down; the last one also unwinds the dead bottom entry.
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h5678, 0, 1));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'h1234, 0, 1));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'hFFFF, 0, 1), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 0, 0, 0));
    // A buffer that takes the arena exactly, then one byte too many.
    add_step(mk_req(MODE_ALLOC, 4093, 16, 16'hA5A5, 0, 0), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 4096, 65536, 1));
    add_step(mk_req(MODE_ALLOC, 1, 1, 16'h5A5A, 0, 0), 1'b1,
             mk_res(ST_ARENA_FULL, 0, 0, 0, 0, 65536, 1));
    add_step(mk_req(MODE_RELEASE, 0, 0, 16'hA5A5, 0, 1), 1'b1,
             mk_res(ST_OK, 0, 0, 0, 0, 0, 0));
    add_step(mk_req(MODE_ALLOC, 320, 200, 16'hC3C3, 0, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: receiver stalls and checking
  // ---------------------------------------------------------------------------

  // The receiver switches between always ready, random stalls, a fixed duty
  // pattern and long choked stretches, each held for a random number of cycles.
  initial begin
    int        left;
    rx_style_t style;
    out_ch.ready = 1'b0;
    left = 0;
    style = RX_OPEN;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = rx_style_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (style)
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_ch.ready <= ($urandom_range(0, 9) < 7);
        end
        RX_PERIODIC: begin
          out_ch.ready <= ((left % 8) >= 3);
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 11) == 0);
        end
      endcase
    end
  end

  task automatic compare_result(input laa_res_t want);
    if (out_ch.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_ch.status);
      mismatches++;
    end
    if (out_ch.from_pool !== want.from_pool) begin
      $error("from_pool: expected %0d, got %0d", want.from_pool, out_ch.from_pool);
      mismatches++;
    end
    if (out_ch.granted_slot !== want.granted_slot) begin
      $error("granted_slot: expected %0d, got %0d", want.granted_slot, out_ch.granted_slot);
      mismatches++;
    end
    if (out_ch.byte_offset !== want.byte_offset) begin
      $error("byte_offset: expected %0d, got %0d", want.byte_offset, out_ch.byte_offset);
      mismatches++;
    end
    if (out_ch.row_pitch !== want.row_pitch) begin
      $error("row_pitch: expected %0d, got %0d", want.row_pitch, out_ch.row_pitch);
      mismatches++;
    end
    if (out_ch.top_after !== want.top_after) begin
      $error("top_after: expected %0d, got %0d", want.top_after, out_ch.top_after);
      mismatches++;
    end
    if (out_ch.depth_after !== want.depth_after) begin
      $error("depth_after: expected %0d, got %0d", want.depth_after, out_ch.depth_after);
      mismatches++;
    end
  endtask

  // Every result item taken is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        compare_result(expected_results.pop_front());
      end
    end
  end

  // The watchdog restarts whenever any channel moves an item or a register write.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ALLOC;
    in_ch.req_width = '0;
    in_ch.req_height = '0;
    in_ch.owner_tag = '0;
    in_ch.release_slot = '0;
    in_ch.release_arena = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SCREEN_WIDTH;
    cfg_ch.data = '0;
    reset_model();
    build_script();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table first, with the reset screen size.
    foreach (script[k]) offer_request(script[k].req, script[k].typed, script[k].want);
    run_random(250);

    // Smallest screen size: every 1 by 1 request now goes to the pool.
    settle_block();
    write_screen_reg(CFG_SCREEN_WIDTH, 1);
    write_screen_reg(CFG_SCREEN_HEIGHT, 1);
    run_random(120);

    // Largest screen size, then the stack is driven into its limit.
    settle_block();
    write_screen_reg(CFG_SCREEN_WIDTH, 4095);
    write_screen_reg(CFG_SCREEN_HEIGHT, 4095);
    run_random(120);
    exercise_stack_limit();

    // A random screen size in the range the small random allocations use.
    settle_block();
    write_screen_reg(CFG_SCREEN_HEIGHT, $urandom_range(1, 32));
    write_screen_reg(CFG_SCREEN_WIDTH, $urandom_range(1, 64));
    run_random(250);

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
